// File: hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the LSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int unsigned DEF_MAX_FIELD_BITS = 64;

  // Field widths fixed by the stream format
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned FVAL_W      = 64;
  localparam int unsigned FWID_W      = 7;
  localparam int unsigned BUF_BYTES_W = 13;
  localparam int unsigned BITS_USED_W = 16;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [BUF_BYTES_W-1:0] BUF_BYTES_RST = 13'd1024;

  // Commands carried on in_tuser
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALIGN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // One step of the shared byte-assembly unit
  typedef struct packed {
    logic [7:0] data;      // assembled byte
    logic       data_vld;  // a full byte was completed
    logic       done;      // this step ends the current append
    logic [6:0] pbits;     // next partial byte bits
    logic [2:0] pcount;    // next partial bit count
  } step_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs bit fields LSB first into a byte stream bounded by a byte capacity.
// ----------------------------------------------------------------------------
// Input beats carry a command on in_tuser (append, align, flush) and, for
// append, a field value and width on in_tdata. Each input beat yields one to
// eight output beats; out_tlast marks the final one. out_tuser[0] flags a
// stream byte on out_tdata, out_tuser[1] drops low on a rejected append.
// Write the capacity in bytes on cfg_wr_en / cfg_wr_data only while idle.
// Align, flush, unknown, rejected and zero-width beats load their one result
// at the accepting edge and leave the sequencer idle. A nonzero append
// latches the field at the accepting edge; from the RUN state the shared
// step unit then emits one result per cycle while the output is free.
// in_tready is high only when the sequencer is idle and the output is free.
// Reset (rst_n, synchronous, active low) empties the partial byte, clears
// the bit count and restores the capacity to 1024 bytes.
// When out_tready is low the output register holds its beat and the
// sequencer stalls; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_first_bit_packer #(
  parameter int unsigned MAX_FIELD_BITS = lbp_pkg::DEF_MAX_FIELD_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // config
  input  wire logic                               cfg_wr_en,
  input  wire logic [lbp_pkg::BUF_BYTES_W-1:0]    cfg_wr_data,  // buffer_bytes
  // input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lbp_pkg::IN_TDATA_W-1:0]     in_tdata,     // field_value[63:0],
                                                                // field_width[70:64], pad
  input  wire logic [lbp_pkg::CMD_W-1:0]          in_tuser,     // command
  // output stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [7:0]                              out_tdata,    // out_byte
  output logic [lbp_pkg::OUT_TUSER_W-1:0]         out_tuser,    // byte_valid, accepted
  output logic                                    out_tlast     // last
);
  import lbp_pkg::*;

  localparam int unsigned WW = $clog2(MAX_FIELD_BITS + 1);

  // Control state
  state_t                  state_r, state_nxt;
  logic [BUF_BYTES_W-1:0]  buf_bytes_r;
  logic [6:0]              pbits_r, pbits_nxt;
  logic [2:0]              pcount_r, pcount_nxt;
  logic [BITS_USED_W-1:0]  bits_used_r, bits_used_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Working field and output payload
  logic [MAX_FIELD_BITS-1:0] value_r, value_nxt;
  logic [WW-1:0]             width_r, width_nxt;
  logic [7:0]                out_data_r, out_data_nxt;
  logic                      out_bv_r, out_bv_nxt;
  logic                      out_acc_r, out_acc_nxt;
  logic                      out_last_r, out_last_nxt;

  // Input fields
  logic [CMD_W-1:0]  cmd;
  logic [FVAL_W-1:0] fval;
  logic [FWID_W-1:0] fwid;

  assign cmd  = in_tuser;
  assign fval = in_tdata[FVAL_W-1:0];
  assign fwid = in_tdata[FVAL_W +: FWID_W];

  // Capacity check
  logic [BITS_USED_W-1:0]    cap;
  logic [BITS_USED_W-1:0]    left;
  logic [FWID_W-1:0]         wsat;
  logic                      fits;
  logic [MAX_FIELD_BITS-1:0] fmask;

  assign cap   = {buf_bytes_r, 3'b000};
  assign left  = (bits_used_r < cap) ? (cap - bits_used_r) : '0;
  assign wsat  = (fwid > FWID_W'(MAX_FIELD_BITS)) ? FWID_W'(MAX_FIELD_BITS) : fwid;
  assign fits  = (BITS_USED_W'(wsat) <= left);
  assign fmask = ~({MAX_FIELD_BITS{1'b1}} << wsat);

  // Handshakes
  logic out_free;
  logic in_fire;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Shared step unit
  step_res_t                 step;
  logic [MAX_FIELD_BITS-1:0] step_value;
  logic [WW-1:0]             step_width;

  lbp_step_unit #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .WW             (WW)
  ) u_step (
    .value     (value_r),
    .width     (width_r),
    .pbits     (pbits_r),
    .pcount    (pcount_r),
    .res       (step),
    .value_nxt (step_value),
    .width_nxt (step_width)
  );

  always_comb begin
    state_nxt     = state_r;
    pbits_nxt     = pbits_r;
    pcount_nxt    = pcount_r;
    bits_used_nxt = bits_used_r;
    value_nxt     = value_r;
    width_nxt     = width_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_bv_nxt    = out_bv_r;
    out_acc_nxt   = out_acc_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // default: an empty, accepted, final beat
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_bv_nxt    = 1'b0;
          out_acc_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          case (cmd)
            CMD_APPEND: begin
              if (!fits) begin
                out_acc_nxt = 1'b0;
              end else begin
                bits_used_nxt = bits_used_r + BITS_USED_W'(wsat);
                if (wsat != '0) begin
                  // hand the field to the step unit; results come from RUN
                  out_valid_nxt = 1'b0;
                  value_nxt     = fval[MAX_FIELD_BITS-1:0] & fmask;
                  width_nxt     = WW'(wsat);
                  state_nxt     = ST_RUN;
                end
              end
            end
            CMD_ALIGN, CMD_FLUSH: begin
              if (pcount_r != '0) begin
                bits_used_nxt = bits_used_r + BITS_USED_W'(4'd8 - {1'b0, pcount_r});
                out_data_nxt  = {1'b0, pbits_r};
                out_bv_nxt    = 1'b1;
                pbits_nxt     = '0;
                pcount_nxt    = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = step.data;
          out_bv_nxt    = step.data_vld;
          out_acc_nxt   = 1'b1;
          out_last_nxt  = step.done;
          pbits_nxt     = step.pbits;
          pcount_nxt    = step.pcount;
          value_nxt     = step_value;
          width_nxt     = step_width;
          if (step.done) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      buf_bytes_r <= BUF_BYTES_RST;
      pbits_r     <= '0;
      pcount_r    <= '0;
      bits_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pbits_r     <= pbits_nxt;
      pcount_r    <= pcount_nxt;
      bits_used_r <= bits_used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        buf_bytes_r <= cfg_wr_data;
      end
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    width_r    <= width_nxt;
    out_data_r <= out_data_nxt;
    out_bv_r   <= out_bv_nxt;
    out_acc_r  <= out_acc_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_acc_r, out_bv_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/lbp_step_unit.sv
// ----------------------------------------------------------------------------
// lbp_step_unit
// Byte-assembly step: merges the partial byte with the next field bits,
// completes at most one byte and shifts the remaining field down.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_step_unit #(
  parameter int unsigned MAX_FIELD_BITS = lbp_pkg::DEF_MAX_FIELD_BITS,
  parameter int unsigned WW             = $clog2(MAX_FIELD_BITS + 1)
) (
  input  wire logic [MAX_FIELD_BITS-1:0] value,
  input  wire logic [WW-1:0]             width,
  input  wire logic [6:0]                pbits,
  input  wire logic [2:0]                pcount,
  output lbp_pkg::step_res_t             res,
  output logic      [MAX_FIELD_BITS-1:0] value_nxt,
  output logic      [WW-1:0]             width_nxt
);
  import lbp_pkg::*;

  logic [3:0]    take;
  logic [WW-1:0] take_ext;
  logic [WW-1:0] rem;

  assign take     = 4'd8 - {1'b0, pcount};
  assign take_ext = WW'(take);
  assign rem      = width - take_ext;

  always_comb begin
    res       = '0;
    value_nxt = value;
    width_nxt = width;
    if (width >= take_ext) begin
      // complete a byte; close out the append when fewer than 8 bits remain
      res.data     = {1'b0, pbits} | 8'(value[7:0] << pcount);
      res.data_vld = 1'b1;
      value_nxt    = value >> take;
      width_nxt    = rem;
      res.done     = (rem < WW'(8));
      if (res.done) begin
        res.pbits  = value_nxt[6:0];
        res.pcount = rem[2:0];
      end
    end else begin
      // field fits in the partial byte
      res.done   = 1'b1;
      res.pbits  = pbits | 7'(value[6:0] << pcount);
      res.pcount = pcount + width[2:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks for the LSB-first bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [7:0]                       out_tdata,
  input wire logic [lbp_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input wire logic                             out_tlast
);

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // A beat without a byte is zero and ends its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("empty beat not final or not zero");

  // A rejected append carries no byte
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> !out_tuser[0] && out_tlast)
    else $error("rejected append carried a byte");

  // No new input while an item still has beats to come
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken mid item");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (.*);

`default_nettype wire

// File: verif/tb_lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer
// Self-checking bench: append, align, flush and unknown command beats against
// a cycle-free model of the packer, through capacity changes and random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lsb_first_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  // The one command code the package does not name: the packer ignores it
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int unsigned MAX_BITS     = DEF_MAX_FIELD_BITS;
  localparam int unsigned RANDOM_ITEMS = 47;    // per random phase
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles without any beat
  localparam int unsigned TAIL_CYCLES  = 20;    // quiet time after the last beat
  localparam int unsigned MAX_REPORTS  = 10;

  // One command beat as the source sees it
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [FVAL_W-1:0] val;
    logic [FWID_W-1:0] wid;
  } pack_cmd_t;

  // One result beat as the sink should see it
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       accepted;
    logic       last;
  } pack_beat_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [BUF_BYTES_W-1:0] cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [CMD_W-1:0]       in_tuser    = CMD_APPEND;
  wire                    out_tvalid;
  logic                   out_tready  = 1'b0;
  wire  [7:0]             out_tdata;
  wire  [OUT_TUSER_W-1:0] out_tuser;
  wire                    out_tlast;

  // Model state: partial byte, bits committed so far, capacity in bytes
  logic [6:0]             pack_bits = '0;
  logic [2:0]             pack_cnt  = '0;
  logic [BITS_USED_W-1:0] used_bits = '0;
  logic [BUF_BYTES_W-1:0] cap_bytes = BUF_BYTES_RST;

  pack_cmd_t   cmd_q[$];           // command beats not yet offered
  pack_beat_t  expected_beats[$];  // result beats still owed by the packer

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned quiet_cycles   = 0;

  lsb_first_bit_packer #(
    .MAX_FIELD_BITS(DEF_MAX_FIELD_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the result beats of one accepted command beat and advance the
  // model state. Bytes leave LSB first as soon as their eighth bit arrives.
  task automatic pack_item(input logic [CMD_W-1:0] cmd, input logic [FVAL_W-1:0] val,
                           input logic [FWID_W-1:0] wid);
    pack_beat_t  beats[$];
    pack_beat_t  b;
    int unsigned w;
    int unsigned take;
    int unsigned room;
    int unsigned cap_bits;
    logic [63:0] v;
    cap_bits = 32'(cap_bytes) * 8;
    // Capacity may sit below the bits already used: then nothing is left
    room = (32'(used_bits) < cap_bits) ? cap_bits - 32'(used_bits) : 0;
    w = (wid > MAX_BITS) ? MAX_BITS : 32'(wid);
    case (cmd)
      CMD_APPEND: begin
        if (w > room) begin
          // Reject: state untouched, no byte
          b = '{data: 8'h00, has_byte: 1'b0, accepted: 1'b0, last: 1'b0};
          beats.push_back(b);
        end else begin
          v = (w >= 64) ? val : (val & ((64'd1 << w) - 64'd1));
          used_bits = used_bits + BITS_USED_W'(w);
          while (w > 0) begin
            take = 8 - 32'(pack_cnt);
            if (w >= take) begin
              b = '{data: 8'(v << pack_cnt) | {1'b0, pack_bits}, has_byte: 1'b1,
                    accepted: 1'b1, last: 1'b0};
              beats.push_back(b);
              v = v >> take;
              w = w - take;
              pack_bits = '0;
              pack_cnt = '0;
            end else begin
              pack_bits = pack_bits | 7'(v << pack_cnt);
              pack_cnt = pack_cnt + 3'(w);
              w = 0;
            end
          end
        end
      end
      CMD_ALIGN, CMD_FLUSH: begin
        // Pad the partial byte with zeros; nothing to do on a byte boundary
        if (pack_cnt != 0) begin
          used_bits = used_bits + BITS_USED_W'(8 - 32'(pack_cnt));
          b = '{data: {1'b0, pack_bits}, has_byte: 1'b1, accepted: 1'b1, last: 1'b0};
          beats.push_back(b);
          pack_bits = '0;
          pack_cnt = '0;
        end
      end
      default: begin
      end
    endcase
    if (beats.size() == 0) begin
      b = '{data: 8'h00, has_byte: 1'b0, accepted: 1'b1, last: 1'b0};
      beats.push_back(b);
    end
    b = beats[beats.size() - 1];
    b.last = 1'b1;
    beats[beats.size() - 1] = b;
    foreach (beats[i]) expected_beats.push_back(beats[i]);
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [FVAL_W-1:0] val,
                           input logic [FWID_W-1:0] wid);
    pack_cmd_t c;
    c = '{cmd: cmd, val: val, wid: wid};
    cmd_q.push_back(c);
  endtask

  // Mostly appends, widths biased toward short fields but reaching the
  // saturating range above the maximum field size
  task automatic push_rand_item();
    int unsigned      r;
    int unsigned      wid;
    logic [63:0]      val;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(99);
    if (r < 70) cmd = CMD_APPEND;
    else if (r < 82) cmd = CMD_ALIGN;
    else if (r < 94) cmd = CMD_FLUSH;
    else cmd = CMD_UNKNOWN;
    r = $urandom_range(99);
    if (r < 6) wid = 0;
    else if (r < 55) wid = $urandom_range(8, 1);
    else if (r < 85) wid = $urandom_range(63, 9);
    else if (r < 93) wid = 64;
    else wid = $urandom_range(127, 65);
    val = {$urandom(), $urandom()};
    if ($urandom_range(15) == 0) val = '1;
    push_item(cmd, val, FWID_W'(wid));
  endtask

  // Block until every queued beat went in and every owed beat came out
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_tvalid || expected_beats.size() != 0) @(negedge clk);
  endtask

  // Write the capacity register; only call when the packer is idle
  task automatic set_capacity(input logic [BUF_BYTES_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_bytes = v;
    @(negedge clk);
  endtask

  // Source: offer the next queued command beat, with random gaps.
  // Hold the beat until the packer takes it.
  always @(posedge clk) begin : source
    pack_cmd_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, nxt.wid, nxt.val};
        in_tuser  <= nxt.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random back-pressure on the result stream
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: check each result beat against the oldest owed beat, then
  // predict for a command beat taken at the same edge. Its results can
  // only show up at a later edge, so the order inside this block is safe.
  always @(posedge clk) begin : monitor
    pack_beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          note_error($sformatf("mismatch: unexpected beat data %02h tuser %02b last %0b",
                               out_tdata, out_tuser, out_tlast));
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata !== want.data || out_tuser[0] !== want.has_byte ||
              out_tuser[1] !== want.accepted || out_tlast !== want.last) begin
            note_error($sformatf({"mismatch: expected data %02h valid %0b accepted %0b ",
                                  "last %0b, got data %02h valid %0b accepted %0b last %0b"},
                                 want.data, want.has_byte, want.accepted, want.last,
                                 out_tdata, out_tuser[0], out_tuser[1], out_tlast));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pack_item(in_tuser, in_tdata[FVAL_W-1:0], in_tdata[FVAL_W +: FWID_W]);
      end
    end
  end

  // Watchdog: drop the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] rnd;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats at the reset capacity of 1024 bytes
    rnd = {$urandom(), $urandom()};
    push_item(CMD_APPEND, '1, 7'd0);                       // zero width adds nothing
    push_item(CMD_APPEND, 64'h1, 7'd1);
    push_item(CMD_APPEND, '1, 7'd7);                       // completes the first byte
    push_item(CMD_ALIGN, '0, 7'd0);                        // on a boundary: no byte
    push_item(CMD_FLUSH, '0, 7'd0);
    push_item(CMD_APPEND, '1, 7'd64);                      // eight full bytes
    push_item(CMD_APPEND, 64'h0123_4567_89ab_cdef, 7'd3);  // upper value bits ignored
    push_item(CMD_APPEND, '1, 7'd64);                      // crosses eight boundaries
    push_item(CMD_APPEND, 64'hfedc_ba98_7654_3210, 7'd4);  // seven bits pending
    push_item(CMD_APPEND, 64'h8000_0000_0000_0001, 7'd64); // eight bytes, seven left
    push_item(CMD_ALIGN, rnd, 7'd127);                     // pad and emit the partial
    push_item(CMD_APPEND, rnd, 7'd127);                    // width saturates
    push_item(CMD_APPEND, ~rnd, 7'd65);
    push_item(CMD_APPEND, 64'h5, 7'd3);
    push_item(CMD_FLUSH, '1, 7'd64);
    push_item(CMD_UNKNOWN, '1, 7'd127);                    // ignored
    push_item(CMD_APPEND, '0, 7'd64);
    push_item(CMD_APPEND, 64'h15, 7'd5);                   // leave a partial byte

    // Capacity below the bits already used: appends bounce, padding still works
    wait_idle();
    set_capacity(13'd1);
    push_item(CMD_APPEND, '1, 7'd1);
    push_item(CMD_APPEND, '1, 7'd0);
    push_item(CMD_FLUSH, '0, 7'd0);
    push_item(CMD_ALIGN, '0, 7'd0);
    push_item(CMD_APPEND, '1, 7'd64);

    // Exact fill: two bytes of room, a 16-bit field fits, one more bit does not
    wait_idle();
    set_capacity(BUF_BYTES_W'((32'(used_bits) + 7) / 8 + 2));
    push_item(CMD_APPEND, {$urandom(), $urandom()}, 7'd16);
    push_item(CMD_APPEND, 64'h1, 7'd1);

    // Random phases: alternate full capacity with a tight one, and step
    // through the idle patterns on both sides
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      if (p % 2 == 0) begin
        set_capacity(13'd8191);
      end else begin
        set_capacity(BUF_BYTES_W'((32'(used_bits) + 7) / 8 + $urandom_range(60, 8)));
      end
      case (p)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 66;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 66;
        end
        default: begin
          src_idle_pct = 12;
          sink_stall_pct = 12;
        end
      endcase
      repeat (RANDOM_ITEMS) push_rand_item();
    end

    // Drain, then watch for stray beats a little longer
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_step_unit.sv
hw/rtl/lsb_first_bit_packer.sv
hw/rtl/lbp_checker.sv
verif/tb_lsb_first_bit_packer.sv
